### rtl/core/tgr_pkg.sv
// tgr_pkg: shared types, constants and the 5x7 column font for the text glyph renderer
// no dependencies; imported by every module of the renderer
`default_nettype none

package tgr_pkg;

  localparam logic [7:0]  NewlineCode = 8'd10;
  localparam logic [7:0]  CharFirst   = 8'd32;
  localparam logic [7:0]  CharLast    = 8'd126;
  localparam logic [15:0] LineAdvance = 16'd9;
  localparam logic [15:0] CharAdvance = 16'd6;
  localparam logic [2:0]  LastCol     = 3'd4;
  localparam logic [2:0]  LastRow     = 3'd7;
  localparam int          GlyphCount  = 95;
  localparam int          CmdDepth    = 2;
  localparam int          CmdPtrW     = $clog2(CmdDepth);

  typedef struct packed {
    logic [6:0]  glyph;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] fg;
    logic [15:0] bg;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [8:0]  y;
    logic [15:0] color;
    logic        last;
  } pix_t;

  // column 0 in the top byte, column 4 in the bottom byte
  localparam logic [39:0] FontRom [GlyphCount] = '{
    40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  function automatic logic [7:0] glyph_col(logic [6:0] glyph, logic [2:0] col);
    logic [39:0] entry;
    entry = (int'(glyph) < GlyphCount) ? FontRom[glyph] : 40'h0;
    unique case (col)
      3'd0:    glyph_col = entry[39:32];
      3'd1:    glyph_col = entry[31:24];
      3'd2:    glyph_col = entry[23:16];
      3'd3:    glyph_col = entry[15:8];
      3'd4:    glyph_col = entry[7:0];
      default: glyph_col = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/core/text_glyph_pixel_renderer_top.sv
// text_glyph_pixel_renderer_top: 5x7 bitmap text renderer with text cursor
// depends on tgr_pkg, tgr_front, tgr_cmd_fifo, tgr_back
//
//   channel   handshake        payload
//   chars in  push / full      char_code_i, new_string_i, origin_x_i, origin_y_i,
//                              fg_color_i, bg_color_i
//   pixels    empty / pop      pixel_x_o, pixel_y_o, pixel_color_o, last_of_char_o
//
// the pixel scanner walks the 5x8 bits of a character, one glyph bit per cycle while it is not stalled;
// a newline only moves the cursor in the front and sends nothing to the scanner
// the front takes one item per cycle while the two-entry command queue has room
// reset clears cursor, queue count and pointers, scan position and pixel valid flags at once; no clearing pass
// the scanner holds on a pixel to keep while its pending pixel and output register are both full and no pop comes
`default_nettype none

module text_glyph_pixel_renderer_top import tgr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        new_string_i,
  input  wire logic [15:0] origin_x_i,
  input  wire logic [15:0] origin_y_i,
  input  wire logic [15:0] fg_color_i,
  input  wire logic [15:0] bg_color_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pixel_x_o,
  output logic [8:0]       pixel_y_o,
  output logic [15:0]      pixel_color_o,
  output logic             last_of_char_o
);

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  logic out_valid;
  pix_t out_pix;

  tgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code_i),
    .new_string_i (new_string_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .fg_color_i   (fg_color_i),
    .bg_color_i   (bg_color_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  tgr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  tgr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_o       (out_pix)
  );

  assign empty          = !out_valid;
  assign pixel_x_o      = out_pix.x;
  assign pixel_y_o      = out_pix.y;
  assign pixel_color_o  = out_pix.color;
  assign last_of_char_o = out_pix.last;

endmodule

`default_nettype wire

### rtl/core/tgr_front.sv
// tgr_front: accepts characters, keeps the text cursor and issues glyph commands
// depends on tgr_pkg; feeds tgr_cmd_fifo
`default_nettype none

module tgr_front import tgr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        new_string_i,
  input  wire logic [15:0] origin_x_i,
  input  wire logic [15:0] origin_y_i,
  input  wire logic [15:0] fg_color_i,
  input  wire logic [15:0] bg_color_i,
  input  wire logic        cmd_full_i,
  output logic             cmd_push_o,
  output cmd_t             cmd_o
);

  logic [15:0] cursor_x_q, cursor_x_d;
  logic [15:0] cursor_y_q, cursor_y_d;
  logic [15:0] line_start_q, line_start_d;
  logic [15:0] base_x, base_y;
  logic        accept, is_newline;

  assign full       = cmd_full_i;
  assign accept     = push && !cmd_full_i;
  assign is_newline = (char_code_i == NewlineCode);

  always_comb begin
    base_x       = new_string_i ? origin_x_i : cursor_x_q;
    base_y       = new_string_i ? origin_y_i : cursor_y_q;
    line_start_d = new_string_i ? origin_x_i : line_start_q;
    if (is_newline) begin
      cursor_x_d = line_start_d;
      cursor_y_d = base_y + LineAdvance;
    end else begin
      cursor_x_d = base_x + CharAdvance;
      cursor_y_d = base_y;
    end
  end

  always_comb begin
    cmd_o.glyph = (char_code_i < CharFirst || char_code_i > CharLast) ? 7'd0
                : 7'(char_code_i - CharFirst);
    cmd_o.cx    = base_x;
    cmd_o.cy    = base_y;
    cmd_o.fg    = fg_color_i;
    cmd_o.bg    = bg_color_i;
  end

  assign cmd_push_o = accept && !is_newline;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      line_start_q <= '0;
    end else if (accept) begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      line_start_q <= line_start_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tgr_cmd_fifo.sv
// tgr_cmd_fifo: short queue of glyph commands between front and back
// depends on tgr_pkg
`default_nettype none

module tgr_cmd_fifo import tgr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdPtrW:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (CmdPtrW+1)'(CmdDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == CmdDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == CmdDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (CmdPtrW+1)'(CmdDepth))
    else $error("command queue over depth");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push without count increment");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers differ on empty queue");

endmodule

`default_nettype wire

### rtl/core/tgr_back.sv
// tgr_back: scans one glyph bit per cycle unless stalled, clips and colors pixels, holds output register
// depends on tgr_pkg; fed by tgr_cmd_fifo
`default_nettype none

module tgr_back import tgr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic pop_i,
  output logic      out_valid_o,
  output pix_t      out_o
);

  localparam logic [15:0] WidthLim  = 16'(SCREEN_WIDTH);
  localparam logic [15:0] HeightLim = 16'(SCREEN_HEIGHT);

  logic [2:0]  col_q, row_q;
  logic [7:0]  col_bits;
  logic [15:0] px, py;
  logic        set_bit, keep, final_pos, stall, advance, out_free, move;
  pix_t        cand;
  pix_t        pend_q;
  logic        pend_v_q;
  pix_t        out_q;
  logic        out_v_q;

  always_comb begin
    col_bits   = glyph_col(cmd_i.glyph, col_q);
    set_bit    = col_bits[row_q];
    px         = cmd_i.cx + 16'(col_q);
    py         = cmd_i.cy + 16'(row_q);
    final_pos  = (col_q == LastCol) && (row_q == LastRow);
    keep       = cmd_valid_i && (set_bit || (cmd_i.fg != cmd_i.bg))
              && (px < WidthLim) && (py < HeightLim);
    out_free   = !out_v_q || pop_i;
    stall      = keep && pend_v_q && !out_free;
    advance    = cmd_valid_i && !stall;
    move       = pend_v_q && out_free && (pend_q.last || keep);
    cand.x     = px[7:0];
    cand.y     = py[8:0];
    cand.color = set_bit ? cmd_i.fg : cmd_i.bg;
    cand.last  = final_pos;
  end

  assign cmd_pop_o   = advance && final_pos;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // scan position, column-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance) begin
      if (row_q == LastRow) begin
        row_q <= '0;
        col_q <= (col_q == LastCol) ? '0 : col_q + 1'b1;
      end else begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  // one-deep pending pixel so the final emitted pixel can be tagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (keep && advance) begin
        pend_v_q <= 1'b1;
      end else if (move) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep && advance) begin
      pend_q <= cand;
    end else if (!move && advance && final_pos && pend_v_q) begin
      pend_q.last <= 1'b1;
    end
    if (move) begin
      out_q <= pend_q;
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LastCol)
    else $error("scan column out of range");

  a_idle_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> (col_q == '0 && row_q == '0))
    else $error("scan position not at origin while idle");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_v_q && pend_q.last && out_free) |=> out_v_q)
    else $error("tagged pixel not moved to output");

  a_glyph_end_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && pend_v_q && !move) |=> (pend_v_q && pend_q.last))
    else $error("glyph ended without tagging its last pixel");

endmodule

`default_nettype wire
